// ===== rtl/core/bra_pkg.sv =====
// Shared types and constants for the bitmap run allocator.
// No dependencies; imported by the top level, bra_scan and bra_checker.
`default_nettype none

package bra_pkg;

    // Fixed geometry of one map word
    localparam int WORD_BITS    = 64;
    localparam int POS_W        = 6;    // bit position inside a word
    localparam int LEN_W        = 7;    // free-bit count inside a word, 0..64
    localparam int MAP_BITS_DEF = 4096;

    // Port field widths
    localparam int REQ_W   = 2;
    localparam int INDEX_W = 12;
    localparam int COUNT_W = 13;
    localparam int CFG_W   = 13;
    localparam int RUN_W   = 12;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_TEST      = 2'd0;
    localparam logic [REQ_W-1:0] REQ_MARK_USED = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MARK_FREE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_FIND      = 2'd3;

    // Summary of one map word for the first-fit search
    typedef struct packed {
        logic [LEN_W-1:0] lead_free;   // free run starting at bit 0
        logic [LEN_W-1:0] top_free;    // free run ending at the top bit
        logic             hit;         // a whole run fits inside the word
        logic [POS_W-1:0] hit_pos;     // lowest start of such a run
    } t_scan;

endpackage

`default_nettype wire

// ===== rtl/core/bitmap_run_allocator.sv =====
// Channel     | Signals                                          | Handshake
// request     | i_req_type, i_slot_index, i_slot_count           | start && !busy
// result      | o_bit_value, o_found, o_run_start, o_range_error | o_done, one cycle
// config      | i_cfg_data                                       | i_cfg_we
//
// Test: the word is read, the bit taken in S_TEST, then the result. Mark: each map
// word touched is read and written back in turn, then the result. Find: words are
// read in turn from word 0 up to the hit or up to word ceil(bits_in_use/64)-1, then
// the result. Rejected requests, zero-length marks, zero-count finds and finds with
// no bits in use answer from the idle state. After reset and after every config write
// the map is cleared, one word per cycle, with busy high. Results cannot be stalled.
//
// Top level of the bitmap run allocator. Uses bra_pkg, bra_ram and bra_scan.
`default_nettype none

module bitmap_run_allocator import bra_pkg::*; #(
    parameter int MAP_BITS = MAP_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [REQ_W-1:0]   i_req_type,
    input  wire logic [INDEX_W-1:0] i_slot_index,
    input  wire logic [COUNT_W-1:0] i_slot_count,
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    output logic                    o_done,
    output logic                    o_bit_value,
    output logic                    o_found,
    output logic      [RUN_W-1:0]   o_run_start,
    output logic                    o_range_error
);

    localparam int MAP_WORDS = MAP_BITS / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW        = $clog2(MAP_BITS + 1);
    localparam int CW        = (BW > INDEX_W + 2) ? BW : INDEX_W + 2;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_TEST  = 3'd2;
    localparam logic [2:0] S_MARK  = 3'd3;
    localparam logic [2:0] S_FIND  = 3'd4;

    localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

    // Control state
    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_addr, n_addr;
    logic [BW-1:0] r_biu, n_biu;
    logic          r_done, n_done;

    // Request and walk payload
    logic [REQ_W-1:0]   r_req, n_req;
    logic [INDEX_W-1:0] r_idx, n_idx;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic [AW-1:0]      r_first, n_first;
    logic [AW-1:0]      r_last, n_last;
    logic [POS_W-1:0]   r_hi_bit, n_hi_bit;
    logic [CW-1:0]      r_run, n_run;
    logic [CW-1:0]      r_begin, n_begin;

    // Result payload
    logic             r_bit, n_bit;
    logic             r_found, n_found;
    logic [RUN_W-1:0] r_start, n_start;
    logic             r_err, n_err;

    // RAM port
    logic                 ram_we;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;

    // Request decode
    logic          accept;
    logic [CW-1:0] idx_x, cnt_x, biu_x, end_x, endm1_x, cfg_x;
    logic          test_err, mark_err;
    logic [AW-1:0] idx_word;

    // Word handling
    logic [WORD_BITS-1:0] lo_mask, hi_mask, mark_mask;
    logic [WORD_BITS-1:0] valid_mask, free_bits;
    logic [CW-1:0]        base, cand, run_sum;
    logic                 short_cnt;
    t_scan                scan;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    assign idx_x    = CW'(i_slot_index);
    assign cnt_x    = CW'(i_slot_count);
    assign biu_x    = CW'(r_biu);
    assign end_x    = idx_x + cnt_x;
    assign endm1_x  = end_x - CW'(1);
    assign cfg_x    = CW'(i_cfg_data);
    assign test_err = (idx_x >= biu_x);
    assign mark_err = (end_x > biu_x);
    assign idx_word = AW'(idx_x >> POS_W);

    assign lo_mask   = (r_addr == r_first) ? (ONES << r_idx[POS_W-1:0]) : ONES;
    assign hi_mask   = (r_addr == r_last) ?
                       (ONES >> (POS_W'(WORD_BITS - 1) - r_hi_bit)) : ONES;
    assign mark_mask = lo_mask & hi_mask;

    // Slots at or beyond bits_in_use count as used for the search
    assign valid_mask = (CW'(r_addr) < (biu_x >> POS_W)) ? ONES
                                                         : ~(ONES << r_biu[POS_W-1:0]);
    assign free_bits  = ~ram_rdata & valid_mask;

    assign base      = CW'(r_addr) << POS_W;
    assign cand      = (r_run == '0) ? base : r_begin;
    assign run_sum   = r_run + CW'(scan.lead_free);
    assign short_cnt = ((r_cnt >> POS_W) == '0);

    bra_scan u_scan (
        .i_free  (free_bits),
        .i_count (r_cnt),
        .o_scan  (scan)
    );

    bra_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS),
        .ADDR_W(AW)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_addr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_biu    = r_biu;
        n_done   = 1'b0;
        n_req    = r_req;
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_first  = r_first;
        n_last   = r_last;
        n_hi_bit = r_hi_bit;
        n_run    = r_run;
        n_begin  = r_begin;
        n_bit    = r_bit;
        n_found  = r_found;
        n_start  = r_start;
        n_err    = r_err;

        ram_we    = 1'b0;
        ram_wdata = '0;
        ram_raddr = AW'(r_addr + 1'b1);

        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                n_addr = AW'(r_addr + 1'b1);
                if (r_addr == AW'(MAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                ram_raddr = (i_req_type == REQ_FIND) ? '0 : idx_word;
                if (accept) begin
                    n_req   = i_req_type;
                    n_idx   = i_slot_index;
                    n_cnt   = i_slot_count;
                    n_bit   = 1'b0;
                    n_found = 1'b0;
                    n_start = '0;
                    n_err   = 1'b0;
                    case (i_req_type)
                        REQ_TEST: begin
                            if (test_err) begin
                                n_err  = 1'b1;
                                n_done = 1'b1;
                            end else begin
                                n_state = S_TEST;
                            end
                        end
                        REQ_MARK_USED, REQ_MARK_FREE: begin
                            if (mark_err) begin
                                n_err  = 1'b1;
                                n_done = 1'b1;
                            end else if (cnt_x == '0) begin
                                n_done = 1'b1;
                            end else begin
                                n_state  = S_MARK;
                                n_addr   = idx_word;
                                n_first  = idx_word;
                                n_last   = AW'(endm1_x >> POS_W);
                                n_hi_bit = endm1_x[POS_W-1:0];
                            end
                        end
                        REQ_FIND: begin
                            if (cnt_x == '0 || biu_x == '0) begin
                                n_done = 1'b1;
                            end else begin
                                n_state = S_FIND;
                                n_addr  = '0;
                                n_last  = AW'((biu_x - CW'(1)) >> POS_W);
                                n_run   = '0;
                                n_begin = '0;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end

            S_TEST: begin
                n_bit   = ram_rdata[r_idx[POS_W-1:0]];
                n_done  = 1'b1;
                n_state = S_IDLE;
            end

            S_MARK: begin
                // Write back this word while the next one is read
                ram_we    = 1'b1;
                ram_wdata = (r_req == REQ_MARK_USED) ? (ram_rdata | mark_mask)
                                                     : (ram_rdata & ~mark_mask);
                if (r_addr == r_last) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_addr = AW'(r_addr + 1'b1);
                end
            end

            S_FIND: begin
                if (run_sum >= CW'(r_cnt)) begin
                    // Run carried in from below, or starting at bit 0, completes in this word
                    n_found = 1'b1;
                    n_start = RUN_W'(cand);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (short_cnt && scan.hit) begin
                    n_found = 1'b1;
                    n_start = RUN_W'(base + CW'(scan.hit_pos));
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (r_addr == r_last) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_addr = AW'(r_addr + 1'b1);
                    if (scan.lead_free == LEN_W'(WORD_BITS)) begin
                        n_run   = run_sum;
                        n_begin = cand;
                    end else begin
                        n_run   = CW'(scan.top_free);
                        n_begin = base + CW'(WORD_BITS) - CW'(scan.top_free);
                    end
                end
            end

            default: begin
                n_state = S_CLEAR;
                n_addr  = '0;
            end
        endcase

        // Reload the slot count and restart the clearing sweep
        if (i_cfg_we) begin
            n_biu   = (cfg_x > CW'(MAP_BITS)) ? BW'(MAP_BITS) : BW'(cfg_x);
            n_state = S_CLEAR;
            n_addr  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_biu   <= BW'(MAP_BITS);
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_biu   <= n_biu;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_idx    <= n_idx;
        r_cnt    <= n_cnt;
        r_first  <= n_first;
        r_last   <= n_last;
        r_hi_bit <= n_hi_bit;
        r_run    <= n_run;
        r_begin  <= n_begin;
        r_bit    <= n_bit;
        r_found  <= n_found;
        r_start  <= n_start;
        r_err    <= n_err;
    end

    assign o_done        = r_done;
    assign o_bit_value   = r_bit;
    assign o_found       = r_found;
    assign o_run_start   = r_start;
    assign o_range_error = r_err;

endmodule

`default_nettype wire

// ===== rtl/core/bra_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bra_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/bra_scan.sv =====
// Word scanner for the first-fit search: free-run lengths at both ends of a
// map word and the lowest in-word run of a short count. Uses bra_pkg.
`default_nettype none

module bra_scan import bra_pkg::*; (
    input  wire logic [WORD_BITS-1:0] i_free,
    input  wire logic [COUNT_W-1:0]   i_count,
    output t_scan                     o_scan
);

    always_comb begin
        logic [WORD_BITS-1:0] span;     // runs of 2^b free bits by start
        logic [WORD_BITS-1:0] win;      // runs of the accumulated length
        logic                 have;
        logic [LEN_W-1:0]     lead;
        logic [LEN_W-1:0]     top;
        logic [POS_W-1:0]     pos;

        span = i_free;
        win  = '0;
        have = 1'b0;
        // Build the window for the low count bits by doubling run lengths
        for (int b = 0; b < POS_W; b++) begin
            if (i_count[b]) begin
                win  = have ? (span & (win >> (1 << b))) : span;
                have = 1'b1;
            end
            span = span & (span >> (1 << b));
        end

        pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (win[j]) begin
                pos = POS_W'(j);
            end
        end

        lead = LEN_W'(WORD_BITS);
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (!i_free[j]) begin
                lead = LEN_W'(j);
            end
        end

        top = LEN_W'(WORD_BITS);
        for (int j = 0; j < WORD_BITS; j++) begin
            if (!i_free[j]) begin
                top = LEN_W'(WORD_BITS - 1 - j);
            end
        end

        o_scan.lead_free = lead;
        o_scan.top_free  = top;
        o_scan.hit       = |win;
        o_scan.hit_pos   = pos;
    end

endmodule

`default_nettype wire

// ===== rtl/core/bra_checker.sv =====
// Port-level checks for the bitmap run allocator, bound to the top level.
// Uses bra_pkg for the port widths.
`default_nettype none

module bra_checker import bra_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               i_cfg_we,
    input wire logic               o_done,
    input wire logic               o_bit_value,
    input wire logic               o_found,
    input wire logic [RUN_W-1:0]   o_run_start,
    input wire logic               o_range_error
);

    // An accepted beat either answers at once or holds the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_cfg_we) |=> (busy || o_done))
        else $error("accepted beat neither answered nor held busy");

    // A config write always starts the clearing sweep
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> busy)
        else $error("config write did not start the clearing sweep");

    // A rejected request carries no other result
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_range_error) |-> (!o_found && !o_bit_value && o_run_start == '0))
        else $error("rejected request reports a result");

    // No run start without a find hit
    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_found) |-> (o_run_start == '0))
        else $error("run start set without a hit");

    // A result is either a test or a find, never both
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_bit_value && o_found))
        else $error("test and find result mixed");

endmodule

bind bitmap_run_allocator bra_checker u_bra_checker (.*);

`default_nettype wire
